// ----- rtl/audio_peak_level_meter_top_defines.svh -----
// Assertion macros for the peak level meter.
`ifndef AUDIO_PEAK_LEVEL_METER_TOP_DEFINES_SVH
`define AUDIO_PEAK_LEVEL_METER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property while out of reset.
`define APLM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("peak level meter check failed");
// Check a property on the cycle after reset is applied.
`define APLM_ASSERT_AFTER_RST(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) !rstn |=> prop) \
        else $error("peak level meter reset check failed");
`else
`define APLM_ASSERT(lbl, clk, rstn, prop)
`define APLM_ASSERT_AFTER_RST(lbl, clk, rstn, prop)
`endif
`endif

// ----- rtl/aplm_pkg.sv -----
// Shared types, codes and constants of the peak level meter.
package aplm_pkg;

    localparam int DATA_W          = 32;
    localparam int LEVEL_FRAC_BITS = 16;
    localparam int LEVEL_W         = LEVEL_FRAC_BITS + 1;
    localparam int STEP_W          = $clog2(LEVEL_FRAC_BITS + 1);
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LEVEL_W-1:0] LEVEL_ONE = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

    // Register indexes
    localparam logic [1:0] CFG_SAMPLE_WIDTH = 2'd0;
    localparam logic [1:0] CFG_SAMPLE_KIND  = 2'd1;
    localparam logic [1:0] CFG_BIG_ENDIAN   = 2'd2;
    localparam logic [1:0] CFG_FULL_SCALE   = 2'd3;

    // Sample width codes
    localparam logic [1:0] WIDTH_8  = 2'd0;
    localparam logic [1:0] WIDTH_16 = 2'd1;
    localparam logic [1:0] WIDTH_32 = 2'd2;

    // Sample kind codes
    localparam logic [1:0] KIND_UNSIGNED = 2'd0;
    localparam logic [1:0] KIND_SIGNED   = 2'd1;
    localparam logic [1:0] KIND_FLOAT    = 2'd2;

    // Reset values
    localparam logic [1:0]        RST_SAMPLE_WIDTH = WIDTH_16;
    localparam logic [1:0]        RST_SAMPLE_KIND  = KIND_SIGNED;
    localparam logic              RST_BIG_ENDIAN   = 1'b0;
    localparam logic [DATA_W-1:0] RST_FULL_SCALE   = 32'd32767;

    // Float decode: scale is 2^31 - 1
    localparam int         FLOAT_SCALE_SHIFT = 31;
    localparam int         FLOAT_PROD_W      = 24 + FLOAT_SCALE_SHIFT;
    localparam logic [7:0] FLOAT_EXP_SPECIAL = 8'hff;
    localparam logic [7:0] FLOAT_EXP_LIMIT   = 8'd150;

    typedef struct packed {
        logic [1:0]        sample_width;
        logic [1:0]        sample_kind;
        logic              big_endian;
        logic [DATA_W-1:0] full_scale;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic nonempty;
    } q_stat_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIVIDE,
        BK_FINISH
    } back_state_t;

endpackage

// ----- rtl/audio_peak_level_meter_top.sv -----
// Peak level meter for one PCM channel: each input word is one sample, bytes in
// stream order, decoded by the configured width, kind and byte order into a
// magnitude, and the largest magnitude of a buffer is kept. On the word marked
// last, the peak is clamped to full scale and one result word carries the peak
// and the level, peak / full scale as an unsigned Q1.16 truncated fraction;
// with a full scale of zero no result is given. Sample words are taken at one
// per cycle unless a buffer end waits on a full queue; a decode register sits
// before the peak update. Each buffer result goes through a shared restoring
// divider in the back part that takes one quotient bit per cycle over 17 steps
// and then loads the output register. A two-entry queue of peaks sits between
// the parts, so input stalls only when buffer ends arrive faster than the
// divider drains them or the receiver holds results back.
// Configuration is written through cfg_wr_en, cfg_addr and cfg_wdata; the user
// must write it only while the block is idle, which the block does not enforce.
`include "audio_peak_level_meter_top_defines.svh"

module audio_peak_level_meter_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_addr,
    input  logic [aplm_pkg::DATA_W-1:0]   cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [aplm_pkg::DATA_W-1:0]   s_sample_word,
    input  logic                          s_last,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [aplm_pkg::DATA_W-1:0]   m_peak,
    output logic [aplm_pkg::LEVEL_W-1:0]  m_level
);

    aplm_pkg::cfg_t              cfg_reg, cfg_next;
    aplm_pkg::q_stat_t           q_stat;
    logic                        q_push;
    logic [aplm_pkg::DATA_W-1:0] q_push_data;
    logic                        q_pop;
    logic [aplm_pkg::DATA_W-1:0] q_pop_data;

    // Register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                aplm_pkg::CFG_SAMPLE_WIDTH: cfg_next.sample_width = cfg_wdata[1:0];
                aplm_pkg::CFG_SAMPLE_KIND:  cfg_next.sample_kind  = cfg_wdata[1:0];
                aplm_pkg::CFG_BIG_ENDIAN:   cfg_next.big_endian   = cfg_wdata[0];
                aplm_pkg::CFG_FULL_SCALE:   cfg_next.full_scale   = cfg_wdata;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sample_width <= aplm_pkg::RST_SAMPLE_WIDTH;
            cfg_reg.sample_kind  <= aplm_pkg::RST_SAMPLE_KIND;
            cfg_reg.big_endian   <= aplm_pkg::RST_BIG_ENDIAN;
            cfg_reg.full_scale   <= aplm_pkg::RST_FULL_SCALE;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    aplm_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample_word (s_sample_word),
        .s_last        (s_last),
        .q_stat        (q_stat),
        .q_push        (q_push),
        .q_data        (q_push_data)
    );

    aplm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .stat      (q_stat)
    );

    aplm_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .full_scale (cfg_reg.full_scale),
        .q_stat     (q_stat),
        .q_data     (q_pop_data),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_peak     (m_peak),
        .m_level    (m_level)
    );

    // Queue never written when full nor read when empty
    `APLM_ASSERT(a_queue_no_overflow, aclk, aresetn, q_push |-> !q_stat.full)
    `APLM_ASSERT(a_queue_no_underflow, aclk, aresetn, q_pop |-> q_stat.nonempty)
    // A presented word stays within full scale and a level of one
    `APLM_ASSERT(a_out_in_range, aclk, aresetn, m_valid |-> ((m_peak <= cfg_reg.full_scale) && (m_level <= aplm_pkg::LEVEL_ONE)))
    // No word is presented straight after reset
    `APLM_ASSERT_AFTER_RST(a_reset_out_idle, aclk, aresetn, !m_valid)

endmodule

// ----- rtl/aplm_front.sv -----
// Front part: takes sample words, decodes magnitude and tracks the buffer peak.
module aplm_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  aplm_pkg::cfg_t                cfg,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [aplm_pkg::DATA_W-1:0]   s_sample_word,
    input  logic                          s_last,
    input  aplm_pkg::q_stat_t             q_stat,
    output logic                          q_push,
    output logic [aplm_pkg::DATA_W-1:0]   q_data
);

    // |f| * (2^31 - 1), truncated and saturated; NaN gives zero
    function automatic logic [aplm_pkg::DATA_W-1:0] float_mag(
        input logic [aplm_pkg::DATA_W-1:0] bits
    );
        logic [7:0]                          ex;
        logic [23:0]                         man;
        logic [7:0]                          sh;
        logic [aplm_pkg::FLOAT_PROD_W-1:0]   prod;
        logic [aplm_pkg::FLOAT_PROD_W-1:0]   shifted;
        logic [aplm_pkg::DATA_W-1:0]         res;
        ex      = bits[30:23];
        man     = {1'b0, bits[22:0]};
        sh      = '0;
        prod    = '0;
        shifted = '0;
        if (ex == aplm_pkg::FLOAT_EXP_SPECIAL) begin
            res = (man != '0) ? '0 : '1;
        end else begin
            if (ex == 8'd0) begin
                ex = 8'd1;
            end else begin
                man[23] = 1'b1;
            end
            if (ex >= aplm_pkg::FLOAT_EXP_LIMIT) begin
                res = (man != '0) ? '1 : '0;
            end else begin
                sh   = aplm_pkg::FLOAT_EXP_LIMIT - ex;
                prod = {man, {aplm_pkg::FLOAT_SCALE_SHIFT{1'b0}}}
                     - {{aplm_pkg::FLOAT_SCALE_SHIFT{1'b0}}, man};
                if (sh >= 8'd64) begin
                    res = '0;
                end else begin
                    shifted = prod >> sh[5:0];
                    if (shifted[aplm_pkg::FLOAT_PROD_W-1:aplm_pkg::DATA_W] != '0) begin
                        res = '1;
                    end else begin
                        res = shifted[aplm_pkg::DATA_W-1:0];
                    end
                end
            end
        end
        return res;
    endfunction

    // Turn one raw word into an unsigned magnitude
    function automatic logic [aplm_pkg::DATA_W-1:0] decode_mag(
        input logic [aplm_pkg::DATA_W-1:0] w,
        input aplm_pkg::cfg_t              c
    );
        logic [7:0]                  v8;
        logic [15:0]                 v16;
        logic [aplm_pkg::DATA_W-1:0] v32;
        logic [aplm_pkg::DATA_W-1:0] res;
        v8  = w[7:0];
        v16 = c.big_endian ? {w[7:0], w[15:8]} : w[15:0];
        v32 = c.big_endian ? {w[7:0], w[15:8], w[23:16], w[31:24]} : w;
        res = '0;
        unique case (c.sample_width)
            aplm_pkg::WIDTH_8: begin
                unique case (c.sample_kind)
                    aplm_pkg::KIND_UNSIGNED: res = {24'd0, v8};
                    aplm_pkg::KIND_SIGNED:
                        res = v8[7] ? (32'd256 - {24'd0, v8}) : {24'd0, v8};
                    default: res = '0;
                endcase
            end
            aplm_pkg::WIDTH_16: begin
                unique case (c.sample_kind)
                    aplm_pkg::KIND_UNSIGNED: res = {16'd0, v16};
                    aplm_pkg::KIND_SIGNED:
                        res = v16[15] ? (32'h0001_0000 - {16'd0, v16}) : {16'd0, v16};
                    default: res = '0;
                endcase
            end
            aplm_pkg::WIDTH_32: begin
                unique case (c.sample_kind)
                    aplm_pkg::KIND_UNSIGNED: res = v32;
                    aplm_pkg::KIND_SIGNED:   res = v32[31] ? (32'd0 - v32) : v32;
                    aplm_pkg::KIND_FLOAT:    res = float_mag(v32);
                    default:                 res = '0;
                endcase
            end
            default: res = '0;
        endcase
        return res;
    endfunction

    logic                        dec_valid_reg, dec_valid_next;
    logic [aplm_pkg::DATA_W-1:0] dec_mag_reg;
    logic                        dec_last_reg;
    logic [aplm_pkg::DATA_W-1:0] peak_reg, peak_next;
    logic [aplm_pkg::DATA_W-1:0] merged;
    logic                        dec_push;
    logic                        dec_fire;
    logic                        s_accept;

    // Retire the decoded word unless its peak cannot enter a full queue
    always_comb begin
        merged   = (dec_mag_reg > peak_reg) ? dec_mag_reg : peak_reg;
        dec_push = dec_valid_reg && dec_last_reg && (cfg.full_scale != '0);
        dec_fire = dec_valid_reg && !(dec_push && q_stat.full);
        s_ready  = !dec_valid_reg || dec_fire;
        s_accept = s_valid && s_ready;
        q_push   = dec_push && dec_fire;
        q_data   = merged;
    end

    // Advance the decode stage and the running peak
    always_comb begin
        dec_valid_next = dec_valid_reg;
        if (s_accept) begin
            dec_valid_next = 1'b1;
        end else if (dec_fire) begin
            dec_valid_next = 1'b0;
        end
        peak_next = peak_reg;
        if (dec_fire) begin
            peak_next = dec_last_reg ? '0 : merged;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dec_valid_reg <= 1'b0;
            peak_reg      <= '0;
        end else begin
            dec_valid_reg <= dec_valid_next;
            peak_reg      <= peak_next;
        end
    end

    // Hold the decoded word
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            dec_mag_reg  <= decode_mag(s_sample_word, cfg);
            dec_last_reg <= s_last;
        end
    end

endmodule

// ----- rtl/aplm_queue.sv -----
// Short queue of buffer peaks between the front and back parts.
module aplm_queue (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  logic [aplm_pkg::DATA_W-1:0]   push_data,
    input  logic                          pop,
    output logic [aplm_pkg::DATA_W-1:0]   pop_data,
    output aplm_pkg::q_stat_t             stat
);

    logic [aplm_pkg::DATA_W-1:0] mem_reg [aplm_pkg::QUEUE_DEPTH];
    logic [aplm_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [aplm_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [aplm_pkg::QCNT_W-1:0] count_reg, count_next;

    localparam logic [aplm_pkg::QPTR_W-1:0] PTR_LAST =
        aplm_pkg::QPTR_W'(aplm_pkg::QUEUE_DEPTH - 1);
    localparam logic [aplm_pkg::QCNT_W-1:0] CNT_FULL =
        aplm_pkg::QCNT_W'(aplm_pkg::QUEUE_DEPTH);

    // Status and head word
    always_comb begin
        stat.full     = (count_reg == CNT_FULL);
        stat.nonempty = (count_reg != '0);
        pop_data      = mem_reg[rd_ptr_reg];
    end

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/aplm_back.sv -----
// Back part: clamps a buffer peak, divides it by full scale and presents the word.
module aplm_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [aplm_pkg::DATA_W-1:0]    full_scale,
    input  aplm_pkg::q_stat_t              q_stat,
    input  logic [aplm_pkg::DATA_W-1:0]    q_data,
    output logic                           q_pop,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [aplm_pkg::DATA_W-1:0]    m_peak,
    output logic [aplm_pkg::LEVEL_W-1:0]   m_level
);

    localparam logic [aplm_pkg::STEP_W-1:0] STEP_LAST =
        aplm_pkg::STEP_W'(aplm_pkg::LEVEL_FRAC_BITS);

    aplm_pkg::back_state_t state_reg, state_next;

    logic [aplm_pkg::STEP_W-1:0]  step_reg, step_next;
    logic [aplm_pkg::DATA_W:0]    rem_reg, rem_next;
    logic [aplm_pkg::LEVEL_W-1:0] quo_reg, quo_next;
    logic [aplm_pkg::DATA_W-1:0]  pk_reg, pk_next;
    logic                         m_valid_reg, m_valid_next;
    logic [aplm_pkg::DATA_W-1:0]  m_peak_reg;
    logic [aplm_pkg::LEVEL_W-1:0] m_level_reg;
    logic [aplm_pkg::DATA_W-1:0]  clamped;
    logic [aplm_pkg::DATA_W:0]    trial;
    logic                         trial_ge;
    logic                         out_free;
    logic                         out_load;

    assign out_free = !m_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            aplm_pkg::BK_IDLE: begin
                if (q_stat.nonempty) begin
                    state_next = aplm_pkg::BK_DIVIDE;
                end
            end
            aplm_pkg::BK_DIVIDE: begin
                if (step_reg == STEP_LAST) begin
                    state_next = aplm_pkg::BK_FINISH;
                end
            end
            aplm_pkg::BK_FINISH: begin
                if (out_free) begin
                    state_next = aplm_pkg::BK_IDLE;
                end
            end
            default: state_next = aplm_pkg::BK_IDLE;
        endcase
    end

    // One restoring division step per cycle; the first step has no shift
    always_comb begin
        clamped  = (q_data > full_scale) ? full_scale : q_data;
        trial    = (step_reg == '0) ? rem_reg : {rem_reg[aplm_pkg::DATA_W-1:0], 1'b0};
        trial_ge = (trial >= {1'b0, full_scale});
    end

    // Datapath and handshake outputs
    always_comb begin
        q_pop     = 1'b0;
        out_load  = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        pk_next   = pk_reg;
        unique case (state_reg)
            aplm_pkg::BK_IDLE: begin
                if (q_stat.nonempty) begin
                    q_pop     = 1'b1;
                    pk_next   = clamped;
                    rem_next  = {1'b0, clamped};
                    quo_next  = '0;
                    step_next = '0;
                end
            end
            aplm_pkg::BK_DIVIDE: begin
                rem_next  = trial_ge ? (trial - {1'b0, full_scale}) : trial;
                quo_next  = {quo_reg[aplm_pkg::LEVEL_W-2:0], trial_ge};
                step_next = step_reg + 1'b1;
            end
            aplm_pkg::BK_FINISH: begin
                out_load = out_free;
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= aplm_pkg::BK_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold divider and output words
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        pk_reg  <= pk_next;
        if (out_load) begin
            m_peak_reg  <= pk_reg;
            m_level_reg <= quo_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_peak  = m_peak_reg;
    assign m_level = m_level_reg;

endmodule

// ----- bench/audio_peak_level_meter_top_test.sv -----
// Self-checking bench for the peak level meter: decode, peak, clamp and level per buffer.
`timescale 1ns / 1ps

module audio_peak_level_meter_top_test;

    localparam int DRAIN_CYCLES   = 48;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_WORDS   = 800;
    localparam int MAX_REPORTS    = 20;

    // Register codes the block leaves undefined
    localparam logic [1:0] WIDTH_UNDEF = 2'd3;
    localparam logic [1:0] KIND_UNDEF  = 2'd3;

    localparam logic [63:0] FLOAT_GAIN = 64'h0000_0000_7fff_ffff;

    typedef struct packed {
        logic [aplm_pkg::DATA_W-1:0]  peak;
        logic [aplm_pkg::LEVEL_W-1:0] level;
    } level_result_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_wr_en;
    logic [1:0]                    cfg_addr;
    logic [aplm_pkg::DATA_W-1:0]   cfg_wdata;
    logic                          s_valid;
    logic                          s_ready;
    logic [aplm_pkg::DATA_W-1:0]   s_sample_word;
    logic                          s_last;
    logic                          m_valid;
    logic                          m_ready;
    logic [aplm_pkg::DATA_W-1:0]   m_peak;
    logic [aplm_pkg::LEVEL_W-1:0]  m_level;

    // Model copy of the registers and the buffer peak
    logic [1:0]                    meter_width;
    logic [1:0]                    meter_kind;
    logic                          meter_big_endian;
    logic [aplm_pkg::DATA_W-1:0]   meter_full_scale;
    logic [aplm_pkg::DATA_W-1:0]   peak_so_far;

    level_result_t       expected_levels[$];

    bit tx_stall;
    bit rx_stall;
    bit rx_armed;
    int rx_wait;
    int quiet_cycles = 0;
    int errors = 0;
    int words_sent = 0;
    int results_seen = 0;
    int settings_used = 0;

    audio_peak_level_meter_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample_word (s_sample_word),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_peak        (m_peak),
        .m_level       (m_level)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // Float magnitude scaled by 2^31 - 1, truncated and saturated; NaN reads as zero
    function automatic logic [31:0] scaled_float(input logic [31:0] bits);
        logic [7:0]  ex;
        logic [63:0] man;
        logic [63:0] prod;
        int          sh;
        ex  = bits[30:23];
        man = {41'd0, bits[22:0]};
        if (ex == aplm_pkg::FLOAT_EXP_SPECIAL)
            return (man != 0) ? 32'd0 : 32'hffff_ffff;
        if (ex == 8'd0)
            ex = 8'd1;
        else
            man[23] = 1'b1;
        if (ex >= aplm_pkg::FLOAT_EXP_LIMIT)
            return (man != 0) ? 32'hffff_ffff : 32'd0;
        sh   = int'(aplm_pkg::FLOAT_EXP_LIMIT) - int'(ex);
        prod = (man * FLOAT_GAIN) >> sh;
        if (prod > 64'h0000_0000_ffff_ffff)
            return 32'hffff_ffff;
        return prod[31:0];
    endfunction

    // Turn one raw sample word into an unsigned magnitude under the current settings
    function automatic logic [31:0] word_magnitude(input logic [31:0] w);
        logic [31:0] v;
        case (meter_width)
            aplm_pkg::WIDTH_8: begin
                v = {24'd0, w[7:0]};
                if (meter_kind == aplm_pkg::KIND_UNSIGNED)
                    return v;
                if (meter_kind == aplm_pkg::KIND_SIGNED)
                    return v[7] ? (32'h100 - v) : v;
                return 32'd0;
            end
            aplm_pkg::WIDTH_16: begin
                v = meter_big_endian ? {16'd0, w[7:0], w[15:8]} : {16'd0, w[15:0]};
                if (meter_kind == aplm_pkg::KIND_UNSIGNED)
                    return v;
                if (meter_kind == aplm_pkg::KIND_SIGNED)
                    return v[15] ? (32'h1_0000 - v) : v;
                return 32'd0;
            end
            aplm_pkg::WIDTH_32: begin
                v = meter_big_endian ? {w[7:0], w[15:8], w[23:16], w[31:24]} : w;
                if (meter_kind == aplm_pkg::KIND_UNSIGNED)
                    return v;
                if (meter_kind == aplm_pkg::KIND_SIGNED)
                    return v[31] ? (32'd0 - v) : v;
                if (meter_kind == aplm_pkg::KIND_FLOAT)
                    return scaled_float(v);
                return 32'd0;
            end
            default: return 32'd0;
        endcase
    endfunction

    // Fold an accepted word into the peak; on last queue the clamped peak and its level
    task automatic account_word(input logic [31:0] w, input logic is_last);
        logic [31:0] mag;
        logic [31:0] pk;
        logic [63:0] quot;
        mag = word_magnitude(w);
        if (mag > peak_so_far)
            peak_so_far = mag;
        if (is_last) begin
            pk          = peak_so_far;
            peak_so_far = 32'd0;
            if (meter_full_scale != 32'd0) begin
                if (pk > meter_full_scale)
                    pk = meter_full_scale;
                quot = ({32'd0, pk} << aplm_pkg::LEVEL_FRAC_BITS)
                     / {32'd0, meter_full_scale};
                expected_levels.push_back('{peak: pk,
                                            level: quot[aplm_pkg::LEVEL_W-1:0]});
            end
        end
    endtask

    // Random sample word; float words get exponents near the interesting range
    function automatic logic [31:0] random_word();
        logic [31:0] w;
        w = $urandom;
        if (meter_width == aplm_pkg::WIDTH_32 && meter_kind == aplm_pkg::KIND_FLOAT) begin
            case ($urandom_range(0, 9))
                0:       w[30:23] = aplm_pkg::FLOAT_EXP_SPECIAL;
                1:       w[30:23] = 8'd0;
                default: w[30:23] = 8'($urandom_range(110, 165));
            endcase
            if (meter_big_endian)
                w = {w[7:0], w[15:8], w[23:16], w[31:24]};
        end else if ($urandom_range(0, 3) == 0) begin
            w = w >> $urandom_range(0, 31);
        end
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, want);
    endtask

    // Offer one sample word and hold it until the block takes it
    task automatic send_word(input logic [31:0] w, input logic is_last);
        int gap;
        gap = tx_stall ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_sample_word <= w;
        s_last        <= is_last;
        do @(posedge aclk); while (s_ready !== 1'b1);
        account_word(w, is_last);
        words_sent++;
    endtask

    // Stop sending and let every queued result drain, then let the pipeline settle
    task automatic hold_input(input int settle);
        s_valid <= 1'b0;
        while (expected_levels.size() != 0)
            @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] reg_index, input logic [31:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= reg_index;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (reg_index)
            aplm_pkg::CFG_SAMPLE_WIDTH: meter_width      = value[1:0];
            aplm_pkg::CFG_SAMPLE_KIND:  meter_kind       = value[1:0];
            aplm_pkg::CFG_BIG_ENDIAN:   meter_big_endian = value[0];
            aplm_pkg::CFG_FULL_SCALE:   meter_full_scale = value;
            default: ;
        endcase
    endtask

    // Rewrite all four registers once idle; junk in the upper data bits must be dropped
    task automatic set_config(input logic [1:0] width, input logic [1:0] kind,
                              input logic be, input logic [31:0] fs);
        logic [31:0] junk;
        hold_input(DRAIN_CYCLES);
        junk = $urandom;
        write_reg(aplm_pkg::CFG_SAMPLE_WIDTH, {junk[31:2], width});
        junk = $urandom;
        write_reg(aplm_pkg::CFG_SAMPLE_KIND, {junk[31:2], kind});
        junk = $urandom;
        write_reg(aplm_pkg::CFG_BIG_ENDIAN, {junk[31:1], be});
        write_reg(aplm_pkg::CFG_FULL_SCALE, fs);
        settings_used++;
    endtask

    // Reset settings: 16-bit signed, little endian, full scale 32767
    task automatic test_reset_config();
        send_word(32'h0000_0001, 1'b1);
        send_word(32'hffff_8000, 1'b0);
        send_word(32'h1234_7fff, 1'b1);
        send_word(32'h0000_ffff, 1'b1);
    endtask

    // Each width, kind and byte order, the float specials and the undefined codes
    task automatic test_decode_cases();
        set_config(aplm_pkg::WIDTH_8, aplm_pkg::KIND_SIGNED, 1'b0, 32'd128);
        send_word(32'h0000_0080, 1'b1);
        send_word(32'hffff_ff7f, 1'b0);
        send_word(32'h0000_0001, 1'b1);
        set_config(aplm_pkg::WIDTH_8, aplm_pkg::KIND_UNSIGNED, 1'b1, 32'd255);
        send_word(32'habcd_00ff, 1'b1);
        set_config(aplm_pkg::WIDTH_16, aplm_pkg::KIND_UNSIGNED, 1'b1, 32'd65535);
        send_word(32'hffff_0102, 1'b1);
        set_config(aplm_pkg::WIDTH_32, aplm_pkg::KIND_SIGNED, 1'b1, 32'hffff_ffff);
        send_word(32'h0000_0080, 1'b1);
        set_config(aplm_pkg::WIDTH_32, aplm_pkg::KIND_FLOAT, 1'b0, 32'hffff_ffff);
        send_word(32'h3f80_0000, 1'b1);   // one
        send_word(32'hbf80_0000, 1'b0);   // minus one, sign dropped
        send_word(32'h7fc0_0000, 1'b1);   // NaN reads as zero
        send_word(32'hff80_0000, 1'b1);   // infinity saturates
        send_word(32'h0040_0000, 1'b1);   // subnormal, far below one count
        send_word(32'h5f00_0000, 1'b1);   // huge value saturates
        send_word(32'h3e80_0000, 1'b1);   // a quarter
        set_config(aplm_pkg::WIDTH_16, aplm_pkg::KIND_FLOAT, 1'b0, 32'd32767);
        send_word(32'h3f80_7fff, 1'b1);
        set_config(WIDTH_UNDEF, aplm_pkg::KIND_UNSIGNED, 1'b0, 32'd32767);
        send_word(32'hffff_ffff, 1'b1);
        set_config(aplm_pkg::WIDTH_32, KIND_UNDEF, 1'b0, 32'd32767);
        send_word(32'hffff_ffff, 1'b1);
    endtask

    // Zero full scale gives no result but still clears the peak
    task automatic test_zero_full_scale();
        set_config(aplm_pkg::WIDTH_32, aplm_pkg::KIND_UNSIGNED, 1'b0, 32'd0);
        send_word(32'hffff_ffff, 1'b1);
        set_config(aplm_pkg::WIDTH_32, aplm_pkg::KIND_UNSIGNED, 1'b0, 32'd1000);
        send_word(32'h0000_0005, 1'b1);
    endtask

    // Back-to-back buffer ends fill the peak queue while the receiver stalls
    task automatic test_last_burst();
        set_config(aplm_pkg::WIDTH_32, aplm_pkg::KIND_SIGNED, 1'b0, 32'h7fff_ffff);
        tx_stall = 1'b0;
        rx_stall = 1'b1;
        repeat (16) send_word(random_word(), 1'b1);
        rx_stall = 1'b0;
        repeat (8) send_word(random_word(), 1'b1);
    endtask

    // Random settings per phase, buffers of random length and random stall patterns
    task automatic test_random_buffers();
        int          words;
        int          phase_left;
        int          run_len;
        logic [1:0]  width;
        logic [1:0]  kind;
        logic [31:0] fs;
        words = 0;
        while (words < RANDOM_WORDS) begin
            width = ($urandom_range(0, 9) == 0) ? WIDTH_UNDEF : 2'($urandom_range(0, 2));
            kind  = ($urandom_range(0, 9) == 0) ? KIND_UNDEF  : 2'($urandom_range(0, 2));
            if (width == aplm_pkg::WIDTH_32 && $urandom_range(0, 2) == 0)
                kind = aplm_pkg::KIND_FLOAT;
            case ($urandom_range(0, 9))
                0:       fs = 32'd0;
                1:       fs = 32'd1;
                2:       fs = 32'hffff_ffff;
                3:       fs = 32'h7fff_ffff;
                4:       fs = 32'($urandom_range(1, 255));
                5:       fs = 32'($urandom_range(1, 65535));
                default: fs = $urandom;
            endcase
            set_config(width, kind, 1'($urandom_range(0, 1)), fs);
            tx_stall   = ($urandom_range(0, 3) != 0);
            rx_stall   = ($urandom_range(0, 3) != 0);
            phase_left = $urandom_range(30, 70);
            while (phase_left > 0) begin
                run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40)
                                                      : $urandom_range(1, 5);
                for (int i = 0; i < run_len; i++)
                    send_word(random_word(), i == run_len - 1);
                phase_left -= run_len;
                words      += run_len;
                // hold off now and then until every level has come back
                if ($urandom_range(0, 19) == 0)
                    hold_input(0);
            end
            // leave a buffer open across the next register change
            if ($urandom_range(0, 3) == 0) begin
                send_word(random_word(), 1'b0);
                words++;
            end
        end
    endtask

    // Compare each accepted result with the oldest expected level
    always @(posedge aclk) begin : check_results
        level_result_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (expected_levels.size() == 0) begin
                report_mismatch("unexpected result, peak", m_peak, 32'd0);
            end else begin
                want = expected_levels.pop_front();
                if (m_peak !== want.peak)
                    report_mismatch("peak", m_peak, want.peak);
                if (m_level !== want.level)
                    report_mismatch("level", 32'(m_level), 32'(want.level));
                results_seen++;
            end
        end
    end

    // Receiver: wait a random number of cycles after each result appears
    always @(posedge aclk) begin
        if (m_valid === 1'b1 && m_ready) begin
            rx_armed = 1'b0;
            m_ready <= !rx_stall || ($urandom_range(0, 3) == 0);
        end else if (m_valid === 1'b1) begin
            if (!rx_armed) begin
                rx_wait  = rx_stall ? $urandom_range(0, 11) : 0;
                rx_armed = 1'b1;
            end
            if (rx_wait == 0)
                m_ready <= 1'b1;
            else
                rx_wait--;
        end else begin
            m_ready <= !rx_stall || ($urandom_range(0, 3) == 0);
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn       <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_addr      <= aplm_pkg::CFG_SAMPLE_WIDTH;
        cfg_wdata     <= '0;
        s_valid       <= 1'b0;
        s_sample_word <= '0;
        s_last        <= 1'b0;
        m_ready       <= 1'b0;
        meter_width      = aplm_pkg::RST_SAMPLE_WIDTH;
        meter_kind       = aplm_pkg::RST_SAMPLE_KIND;
        meter_big_endian = aplm_pkg::RST_BIG_ENDIAN;
        meter_full_scale = aplm_pkg::RST_FULL_SCALE;
        peak_so_far      = 32'd0;
        tx_stall         = 1'b1;
        rx_stall         = 1'b1;
        rx_armed         = 1'b0;
        rx_wait          = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_config();
        test_decode_cases();
        test_zero_full_scale();
        test_last_burst();
        test_random_buffers();
        hold_input(DRAIN_CYCLES);

        $display("Sent %0d sample words over %0d register settings, checked %0d buffer levels",
                 words_sent, settings_used, results_seen);
        $display("Mismatches: %0d", errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
